// ===== hw/rtl/dttw_pkg.sv =====
// constants shared by the decimal text to word unit
// holds character codes, range limits and text buffer sizing; no dependencies
package dttw_pkg;

    localparam int TEXT_BUFFER_BYTES = 30;
    // characters looked at per text, one byte of the buffer holds the terminator
    localparam int CHAR_LIMIT        = TEXT_BUFFER_BYTES - 1;
    localparam int COUNT_W           = $clog2(TEXT_BUFFER_BYTES);

    localparam int CHAR_W = 8;
    localparam int WORD_W = 16;

    localparam logic [WORD_W-1:0] SIGNED_LIMIT         = 16'd32767;
    localparam logic [WORD_W-1:0] UNSIGNED_LIMIT       = 16'd65535;
    localparam logic [WORD_W-1:0] SIGNED_LIMIT_DIV10   = 16'(32767 / 10);
    localparam logic [WORD_W-1:0] UNSIGNED_LIMIT_DIV10 = 16'(65535 / 10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;

endpackage

// ===== hw/rtl/decimal_text_to_word_unit.sv =====
// decimal text to 16-bit word converter, one character per transaction
// the result register takes a result as the last character leaves the input register
// throughput: one character per cycle unless stalled, set by multiply-by-ten and range check
// a character with no result never waits on a stalled output; a last character waits for it
// reset: i_rst_n synchronous active low, clears parse state and both valid flags
// depends on dttw_pkg
module decimal_text_to_word_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dttw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                          i_last_char,
    input  logic                          i_signed_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dttw_pkg::WORD_W-1:0]   o_value_word,
    output logic                          o_translated
);
    import dttw_pkg::*;

    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // input register
    logic              r_s1_valid;
    logic [CHAR_W-1:0] r_s1_char;
    logic              r_s1_last;
    logic              r_s1_mode;

    // parse state
    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic               r_mode, n_mode;
    logic [WORD_W-1:0]  r_acc, n_acc;
    logic               r_ovf, n_ovf;
    logic               r_fail, n_fail;
    logic               r_dseen, n_dseen;
    logic [COUNT_W-1:0] r_count, n_count;

    // result register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_value;
    logic              r_translated;

    logic              in_accept;
    logic              s1_go;
    logic              is_digit;
    logic [3:0]        digit;
    logic              add_en;
    logic [WORD_W-1:0] limit;
    logic [WORD_W-1:0] limit_div10;
    logic [WORD_W-1:0] acc_x10;
    logic [WORD_W-1:0] n_value;
    logic              n_ok;

    // a character with no result moves on even while the output is stalled
    assign s1_go      = r_s1_valid && (!r_s1_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign is_digit = (r_s1_char >= CHAR_ZERO) && (r_s1_char <= CHAR_NINE);
    assign digit    = is_digit ? 4'(r_s1_char - CHAR_ZERO) : 4'd0;
    assign acc_x10  = WORD_W'({r_acc, 3'b000}) + WORD_W'({r_acc, 1'b0});

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_fail  = r_fail;
        n_dseen = r_dseen;
        n_count = r_count;
        add_en  = 1'b0;

        // signedness is taken from the first character of a text
        if (r_count == '0) begin
            n_mode = r_s1_mode;
        end
        limit       = n_mode ? SIGNED_LIMIT : UNSIGNED_LIMIT;
        limit_div10 = n_mode ? SIGNED_LIMIT_DIV10 : UNSIGNED_LIMIT_DIV10;

        if (32'(r_count) < CHAR_LIMIT) begin
            n_count = r_count + 1'b1;
            case (r_phase)
                PH_BLANK: begin
                    if (r_s1_char == CHAR_SPACE || r_s1_char == CHAR_TAB) begin
                        n_phase = PH_BLANK;
                    end else if (r_s1_char == CHAR_MINUS) begin
                        if (!n_mode) begin
                            n_fail  = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGN;
                        end
                    end else if (r_s1_char == CHAR_PLUS) begin
                        n_phase = PH_SIGN;
                    end else if (is_digit) begin
                        add_en  = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_fail  = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_SIGN: begin
                    if (is_digit) begin
                        add_en  = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_fail  = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        add_en = 1'b1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (add_en) begin
            n_dseen = 1'b1;
            if (r_acc > limit_div10) begin
                n_ovf = 1'b1;
            end else begin
                // overflow keeps the scaled value; it is never shown
                n_acc = acc_x10;
                if (acc_x10 > limit - WORD_W'(digit)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = acc_x10 + WORD_W'(digit);
                end
            end
        end

        n_ok    = !(n_fail || n_ovf || !n_dseen);
        n_value = n_ok ? (n_neg ? WORD_W'(~n_acc + 1'b1) : n_acc) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_BLANK;
            r_neg       <= 1'b0;
            r_mode      <= 1'b0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_fail      <= 1'b0;
            r_dseen     <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_char  <= i_char_code;
                r_s1_last  <= i_last_char;
                r_s1_mode  <= i_signed_mode;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go && r_s1_last) begin
                r_out_valid  <= 1'b1;
                r_value      <= n_value;
                r_translated <= n_ok;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (s1_go) begin
                if (r_s1_last) begin
                    // ready for the next text
                    r_phase <= PH_BLANK;
                    r_neg   <= 1'b0;
                    r_mode  <= 1'b0;
                    r_acc   <= '0;
                    r_ovf   <= 1'b0;
                    r_fail  <= 1'b0;
                    r_dseen <= 1'b0;
                    r_count <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_mode  <= n_mode;
                    r_acc   <= n_acc;
                    r_ovf   <= n_ovf;
                    r_fail  <= n_fail;
                    r_dseen <= n_dseen;
                    r_count <= n_count;
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value_word = r_value;
    assign o_translated = r_translated;

`ifndef SYNTHESIS
    a_fail_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_translated |-> o_value_word == '0)
        else $error("failed conversion with nonzero value");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CHAR_LIMIT)
        else $error("character count past buffer limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_last |=> r_count == '0 && r_phase == PH_BLANK && o_out_valid)
        else $error("parse state not cleared after last character");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_s1_last && r_out_valid)
        else $error("input stalled with no blocked result");
`endif

endmodule

// ===== test/dttw_word_checker.sv =====
`timescale 1ns / 100ps
// checker for the decimal text to word unit: predicts each parsed word and compares results
// watches both channels of the unit; depends on dttw_pkg
module dttw_word_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [dttw_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_last_char,
    input  logic                        i_signed_mode,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [dttw_pkg::WORD_W-1:0] i_value_word,
    input  logic                        i_translated,
    output int                          o_mismatches,
    output int                          o_outstanding,
    output int                          o_words_seen,
    output int                          o_words_translated
);
    import dttw_pkg::*;

    typedef enum logic [1:0] {
        SCAN_BLANK,
        SCAN_SIGN,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              ok;
    } parsed_word_t;

    parsed_word_t pending_words[$];

    scan_phase_t       scan_phase;
    logic              minus_sign;
    logic              signed_range;
    logic [WORD_W-1:0] acc;
    logic              range_exceeded;
    logic              syntax_bad;
    logic              have_digit;
    int                chars_taken;

    function void clear_text();
        scan_phase     = SCAN_BLANK;
        minus_sign     = 1'b0;
        signed_range   = 1'b0;
        acc            = '0;
        range_exceeded = 1'b0;
        syntax_bad     = 1'b0;
        have_digit     = 1'b0;
        chars_taken    = 0;
    endfunction

    function void add_digit(logic [3:0] d);
        logic [WORD_W-1:0] limit;
        logic [WORD_W-1:0] limit_div10;
        limit       = signed_range ? SIGNED_LIMIT : UNSIGNED_LIMIT;
        limit_div10 = signed_range ? SIGNED_LIMIT_DIV10 : UNSIGNED_LIMIT_DIV10;
        have_digit  = 1'b1;
        if (acc > limit_div10) begin
            range_exceeded = 1'b1;
            return;
        end
        // acc is at most 6553 here, so the product fits in 16 bits
        acc = acc * 16'd10;
        if (acc > limit - WORD_W'(d))
            range_exceeded = 1'b1;
        else
            acc = acc + WORD_W'(d);
    endfunction

    function void scan_char(logic [CHAR_W-1:0] c);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d        = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
        case (scan_phase)
            SCAN_BLANK: begin
                if (c == CHAR_SPACE || c == CHAR_TAB) begin
                end else if (c == CHAR_MINUS) begin
                    // minus is only legal in the signed range
                    if (!signed_range) begin
                        syntax_bad = 1'b1;
                        scan_phase = SCAN_DONE;
                    end else begin
                        minus_sign = 1'b1;
                        scan_phase = SCAN_SIGN;
                    end
                end else if (c == CHAR_PLUS) begin
                    scan_phase = SCAN_SIGN;
                end else if (is_digit) begin
                    add_digit(d);
                    scan_phase = SCAN_DIGITS;
                end else begin
                    syntax_bad = 1'b1;
                    scan_phase = SCAN_DONE;
                end
            end
            SCAN_SIGN: begin
                if (is_digit) begin
                    add_digit(d);
                    scan_phase = SCAN_DIGITS;
                end else begin
                    syntax_bad = 1'b1;
                    scan_phase = SCAN_DONE;
                end
            end
            SCAN_DIGITS: begin
                if (is_digit)
                    add_digit(d);
                else
                    scan_phase = SCAN_DONE;
            end
            default: begin
            end
        endcase
    endfunction

    function void predict_char(logic [CHAR_W-1:0] c, logic last, logic mode);
        parsed_word_t w;
        if (chars_taken == 0)
            signed_range = mode;
        if (chars_taken < CHAR_LIMIT) begin
            scan_char(c);
            chars_taken++;
        end
        if (last) begin
            if (syntax_bad || range_exceeded || !have_digit) begin
                w.word = '0;
                w.ok   = 1'b0;
            end else begin
                w.word = minus_sign ? (~acc + 1'b1) : acc;
                w.ok   = 1'b1;
            end
            pending_words.push_back(w);
            clear_text();
        end
    endfunction

    task report_mismatch(input string what, input logic [WORD_W-1:0] got,
                         input logic [WORD_W-1:0] want);
        $display("ERROR at %0t ns: %s got %0h, expected %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        parsed_word_t want;
        if (!i_rst_n) begin
            clear_text();
            pending_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_char(i_char_code, i_last_char, i_signed_mode);
            if (i_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("result with no text pending", i_value_word, '0);
                end else begin
                    want = pending_words.pop_front();
                    o_words_seen++;
                    if (want.ok)
                        o_words_translated++;
                    if (i_value_word !== want.word)
                        report_mismatch("value_word", i_value_word, want.word);
                    if (i_translated !== want.ok)
                        report_mismatch("translated", WORD_W'(i_translated), WORD_W'(want.ok));
                end
            end
        end
        o_outstanding = pending_words.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// top of the decimal text to word unit testbench: clock, reset, text stimulus and verdict
// depends on dttw_pkg, decimal_text_to_word_unit and dttw_word_checker
module tb_top;
    import dttw_pkg::*;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_ALL_ONE = 8'hff;
    localparam int                ITEM_TARGET  = 1050;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic [CHAR_W-1:0] i_char_code   = '0;
    logic              i_last_char   = 1'b0;
    logic              i_signed_mode = 1'b0;
    logic              i_out_stall   = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [WORD_W-1:0] o_value_word;
    logic              o_translated;

    int mismatches;
    int outstanding;
    int words_seen;
    int words_translated;

    logic [CHAR_W-1:0] text_q[$];
    int                chars_counted = 0;
    int                texts_sent    = 0;
    int                burst_left    = 40;

    always #5 i_clk = ~i_clk;

    decimal_text_to_word_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .i_signed_mode (i_signed_mode),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value_word  (o_value_word),
        .o_translated  (o_translated)
    );

    dttw_word_checker u_word_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_char_code        (i_char_code),
        .i_last_char        (i_last_char),
        .i_signed_mode      (i_signed_mode),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_value_word       (o_value_word),
        .i_translated       (o_translated),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding),
        .o_words_seen       (words_seen),
        .o_words_translated (words_translated)
    );

    function logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 3))
            0: return CHAR_ZERO + 8'($urandom_range(0, 9));
            1: begin
                case ($urandom_range(0, 4))
                    0: return CHAR_SPACE;
                    1: return CHAR_TAB;
                    2: return CHAR_PLUS;
                    3: return CHAR_MINUS;
                    default: return CHAR_NUL;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function void push_blanks(int n);
        repeat (n) text_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    function void push_number(int unsigned v, int zeros);
        logic [CHAR_W-1:0] digs[$];
        repeat (zeros) text_q.push_back(CHAR_ZERO);
        do begin
            digs.push_front(CHAR_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        text_q = {text_q, digs};
    endfunction

    // mostly well-formed numbers, some broken sign sequences, some plain noise
    function void build_random_text();
        int          kind;
        int          zeros;
        int unsigned v;
        text_q = {};
        kind   = $urandom_range(0, 99);
        if (kind < 65) begin
            push_blanks(($urandom_range(0, 15) == 0) ? $urandom_range(20, 30)
                                                     : $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: text_q.push_back(CHAR_PLUS);
                1: text_q.push_back(CHAR_MINUS);
                default: begin
                end
            endcase
            case ($urandom_range(0, 5))
                0: v = $urandom_range(0, 9);
                1: v = $urandom_range(0, 999);
                2: v = $urandom_range(0, 65535);
                3: v = $urandom_range(32760, 32775);
                4: v = $urandom_range(65530, 65545);
                default: v = $urandom_range(0, 9999999);
            endcase
            zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
            if ($urandom_range(0, 31) == 0)
                zeros = $urandom_range(24, 30);
            push_number(v, zeros);
            case ($urandom_range(0, 3))
                1: text_q.push_back(CHAR_NUL);
                2: repeat ($urandom_range(1, 3)) text_q.push_back(noise_char());
                default: begin
                end
            endcase
        end else if (kind < 80) begin
            push_blanks($urandom_range(0, 2));
            text_q.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            case ($urandom_range(0, 3))
                0: begin
                end
                1: text_q.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                2: push_blanks(1);
                default: text_q.push_back(noise_char());
            endcase
        end else begin
            repeat ($urandom_range(1, 8)) text_q.push_back(noise_char());
        end
    endfunction

    task send_char(input logic [CHAR_W-1:0] c, input logic last, input logic mode);
        i_in_valid    = 1'b1;
        i_char_code   = c;
        i_last_char   = last;
        i_signed_mode = mode;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid    = 1'b0;
            i_char_code   = 8'($urandom);
            i_last_char   = 1'($urandom);
            i_signed_mode = 1'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // the mode only matters on the first character, so the rest get random modes
    task send_text(input logic mode);
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1,
                      (i == 0) ? mode : 1'($urandom_range(0, 1)));
        chars_counted += (text_q.size() < CHAR_LIMIT) ? text_q.size() : CHAR_LIMIT;
        texts_sent++;
    endtask

    task wait_drained();
        i_in_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // receiver: a long hold-off right after reset to back the unit up, then random segments
    initial begin
        int seg_len;
        int density;
        wait (i_rst_n);
        @(negedge i_clk);
        i_out_stall = 1'b1;
        repeat (110) @(negedge i_clk);
        forever begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    i_out_stall = 1'b0;
                    repeat (seg_len) @(negedge i_clk);
                end
                9: begin
                    i_out_stall = 1'b1;
                    repeat ($urandom_range(80, 120)) @(negedge i_clk);
                end
                default: begin
                    density = $urandom_range(1, 7);
                    repeat (seg_len) begin
                        i_out_stall = ($urandom_range(0, 7) < density);
                        @(negedge i_clk);
                    end
                end
            endcase
        end
    end

    initial begin
        int next_drain;
        next_drain = 300;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // minus zero, minus in unsigned range, a lone NUL terminator, blanks with plus and a tail,
        // unsigned maximum, signed overflow, non-digit first
        text_q = {CHAR_MINUS, CHAR_ZERO};
        send_text(1'b1);
        text_q = {CHAR_MINUS, CHAR_ZERO + 8'd7};
        send_text(1'b0);
        text_q = {CHAR_NUL};
        send_text(1'b0);
        text_q = {CHAR_SPACE, CHAR_TAB, CHAR_PLUS, CHAR_NINE, CHAR_LOWER_X};
        send_text(1'b1);
        text_q = {};
        push_number(65535, 0);
        send_text(1'b0);
        text_q = {CHAR_MINUS};
        push_number(32768, 0);
        send_text(1'b1);
        text_q = {CHAR_ALL_ONE};
        send_text(1'b1);

        while (chars_counted < ITEM_TARGET) begin
            build_random_text();
            send_text(1'($urandom_range(0, 1)));
            if (chars_counted >= next_drain) begin
                wait_drained();
                next_drain += 300;
            end
        end
        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("run covered %0d texts, %0d characters within the buffer limit",
                 texts_sent, chars_counted);
        $display("%0d words checked, %0d of them translated", words_seen, words_translated);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d words still expected", outstanding);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
